@@ src/csr_element_lookup_assert.svh @@
`ifndef CSR_ELEMENT_LOOKUP_ASSERT_SVH
`define CSR_ELEMENT_LOOKUP_ASSERT_SVH

// Checked at every clock edge outside reset.
`define CSR_EL_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked at every clock edge, reset included.
`define CSR_EL_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ src/csr_el_pkg.sv @@
package csr_el_pkg;

  localparam int DEF_MAX_ROWS    = 1024;
  localparam int DEF_MAX_ENTRIES = 4096;

  localparam int FUNC_W = 2;
  localparam int PTR_W  = 13;
  localparam int IDX_W  = 10;
  localparam int CNT_W  = 11;
  localparam int VAL_W  = 64;
  localparam int ERR_W  = 2;

  localparam logic [FUNC_W-1:0] FUNC_ROW_PTR = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_ENTRY   = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_LOOKUP  = 2'd2;

  localparam logic [ERR_W-1:0] ERR_NONE      = 2'd0;
  localparam logic [ERR_W-1:0] ERR_RANGE     = 2'd1;
  localparam logic [ERR_W-1:0] ERR_ZERO_ROWS = 2'd2;

  localparam int          APB_AW        = 3;
  localparam logic [0:0]  REG_ROW_COUNT = 1'b0;

  typedef struct packed {
    logic [IDX_W-1:0] col;
    logic [VAL_W-1:0] value;
  } entry_word_t;

  localparam int ENTRY_W = $bits(entry_word_t);

endpackage

@@ src/csr_el_if.sv @@
interface csr_el_req_if import csr_el_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [FUNC_W-1:0] func;
  logic [PTR_W-1:0]  slot;
  logic [PTR_W-1:0]  row_start;
  logic [IDX_W-1:0]  row;
  logic [IDX_W-1:0]  column;
  logic [VAL_W-1:0]  value_bits;

  modport source (output valid, func, slot, row_start, row, column, value_bits,
                  input ready);
  modport sink (input valid, func, slot, row_start, row, column, value_bits,
                output ready);
endinterface

interface csr_el_rsp_if import csr_el_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             found;
  logic [VAL_W-1:0] entry_value;
  logic [ERR_W-1:0] error;

  modport source (output valid, found, entry_value, error, input ready);
  modport sink (input valid, found, entry_value, error, output ready);
endinterface

@@ src/csr_el_ram.sv @@
module csr_el_ram import csr_el_pkg::*; #(
  parameter int DEPTH = DEF_MAX_ENTRIES,
  parameter int WIDTH = ENTRY_W,
  parameter int AW    = 12
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ src/csr_el_ctrl.sv @@
`include "csr_element_lookup_assert.svh"

module csr_el_ctrl import csr_el_pkg::*; #(
  parameter int MAX_ROWS    = DEF_MAX_ROWS,
  parameter int MAX_ENTRIES = DEF_MAX_ENTRIES,
  parameter int RA_W        = $clog2(MAX_ROWS + 1),
  parameter int EA_W        = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1
) (
  input  logic              clk,
  input  logic              rst,
  csr_el_req_if.sink        req,
  csr_el_rsp_if.source      rsp,
  input  logic [CNT_W-1:0]  row_count,
  output logic              ptr_we,
  output logic [RA_W-1:0]   ptr_waddr,
  output logic [PTR_W-1:0]  ptr_wdata,
  output logic [RA_W-1:0]   ptr_raddr,
  input  logic [PTR_W-1:0]  ptr_rdata,
  output logic              ent_we,
  output logic [EA_W-1:0]   ent_waddr,
  output entry_word_t       ent_wdata,
  output logic [EA_W-1:0]   ent_raddr,
  input  entry_word_t       ent_rdata
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_PTR0 = 3'd1;
  localparam logic [2:0] S_PTR1 = 3'd2;
  localparam logic [2:0] S_SCAN = 3'd3;
  localparam logic [2:0] S_FIN  = 3'd4;

  logic [2:0]       state;
  logic [IDX_W-1:0] row_q;
  logic [IDX_W-1:0] col_q;
  logic [PTR_W-1:0] ptr_q;
  logic [PTR_W-1:0] end_q;
  logic             pend;
  logic             res_found;
  logic [VAL_W-1:0] res_value;
  logic [ERR_W-1:0] res_err;
  logic             out_valid;
  logic             out_found;
  logic [VAL_W-1:0] out_value;
  logic [ERR_W-1:0] out_err;

  logic             accept;
  logic             lookup_acc;
  logic [CNT_W-1:0] rows_used;
  logic [ERR_W-1:0] lookup_err;
  logic [PTR_W-1:0] end_clamp;
  logic             hit;
  logic             out_free;

  assign req.ready  = (state == S_IDLE);
  assign accept     = req.valid && req.ready;
  assign lookup_acc = accept && (req.func == FUNC_LOOKUP);

  // row_count above the table size acts as the table size
  assign rows_used = (32'(row_count) > 32'(MAX_ROWS)) ? CNT_W'(MAX_ROWS) : row_count;

  always_comb begin
    if (rows_used == '0) begin
      lookup_err = ERR_ZERO_ROWS;
    end else if ((CNT_W'(req.row) >= rows_used) || (CNT_W'(req.column) >= rows_used)) begin
      lookup_err = ERR_RANGE;
    end else begin
      lookup_err = ERR_NONE;
    end
  end

  // loads go straight to the tables in the accept cycle
  assign ptr_we    = accept && (req.func == FUNC_ROW_PTR) && (32'(req.slot) <= 32'(MAX_ROWS));
  assign ptr_waddr = RA_W'(req.slot);
  assign ptr_wdata = req.row_start;

  assign ent_we        = accept && (req.func == FUNC_ENTRY) &&
                         (32'(req.slot) < 32'(MAX_ENTRIES));
  assign ent_waddr     = EA_W'(req.slot);
  assign ent_wdata.col   = req.column;
  assign ent_wdata.value = req.value_bits;

  // row start is fetched while accepting, row end in S_PTR0
  assign ptr_raddr = (state == S_IDLE) ? RA_W'(req.row) : RA_W'(row_q) + RA_W'(1);
  assign ent_raddr = EA_W'(ptr_q);

  assign end_clamp = (32'(ptr_rdata) > 32'(MAX_ENTRIES)) ? PTR_W'(MAX_ENTRIES) : ptr_rdata;

  // one entry read in flight; compare the column that came back
  assign hit      = pend && (ent_rdata.col == col_q);
  assign out_free = !out_valid || rsp.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      pend      <= 1'b0;
    end else begin
      // S_FIN reloads the output register itself
      if (out_valid && rsp.ready && (state != S_FIN)) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (lookup_acc) begin
            row_q <= req.row;
            col_q <= req.column;
            if (lookup_err != ERR_NONE) begin
              res_found <= 1'b0;
              res_value <= '0;
              res_err   <= lookup_err;
              state     <= S_FIN;
            end else begin
              state <= S_PTR0;
            end
          end
        end
        S_PTR0: begin
          ptr_q <= ptr_rdata;
          state <= S_PTR1;
        end
        S_PTR1: begin
          end_q <= end_clamp;
          pend  <= 1'b0;
          state <= S_SCAN;
        end
        S_SCAN: begin
          if (hit) begin
            res_found <= 1'b1;
            res_value <= ent_rdata.value;
            res_err   <= ERR_NONE;
            pend      <= 1'b0;
            state     <= S_FIN;
          end else if (ptr_q >= end_q) begin
            res_found <= 1'b0;
            res_value <= '0;
            res_err   <= ERR_NONE;
            pend      <= 1'b0;
            state     <= S_FIN;
          end else begin
            pend  <= 1'b1;
            ptr_q <= ptr_q + PTR_W'(1);
          end
        end
        S_FIN: begin
          if (out_free) begin
            out_valid <= 1'b1;
            out_found <= res_found;
            out_value <= res_value;
            out_err   <= res_err;
            state     <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign rsp.valid       = out_valid;
  assign rsp.found       = out_found;
  assign rsp.entry_value = out_value;
  assign rsp.error       = out_err;

  `CSR_EL_ASSERT(a_found_no_err, (state == S_FIN && res_found) |-> (res_err == ERR_NONE), "found with error set")
  `CSR_EL_ASSERT(a_err_zero, (state == S_FIN && res_err != ERR_NONE) |-> (!res_found && res_value == '0), "error result not cleared")
  `CSR_EL_ASSERT(a_lookup_fetch, (lookup_acc && lookup_err == ERR_NONE) |=> (state == S_PTR0), "valid lookup did not fetch row pointers")
  `CSR_EL_ASSERT(a_fin_loads_out, (state == S_FIN && out_free) |=> (out_valid && state == S_IDLE), "finished result not registered")
  `CSR_EL_ASSERT_ALWAYS(a_reset_idle, rst |=> (state == S_IDLE && !out_valid), "reset did not idle the sequencer")

endmodule

@@ src/csr_element_lookup.sv @@
// channel  dir  modport  transaction
// req      in   sink     load row pointer, load entry, or lookup (row, column)
// rsp      out  source   lookup answer: found, entry_value, error
// apb      in   slave    row_count at byte address 0
//
// Loads are written in their accept cycle; the next transaction is accepted in the following cycle.
// A lookup runs S_PTR0, S_PTR1, S_SCAN and S_FIN, which registers its result; S_SCAN
// makes one entry column compare per cycle through the entry RAM read port. Range and
// zero-row errors go straight to S_FIN. One lookup at a time is in flight.
// rst is synchronous; table contents are not cleared and are undefined until loaded.
// A result waiting on rsp does not block loads; a second lookup waits in its final state.
module csr_element_lookup import csr_el_pkg::*; #(
  parameter int MAX_ROWS    = DEF_MAX_ROWS,
  parameter int MAX_ENTRIES = DEF_MAX_ENTRIES
) (
  input  logic              clk,
  input  logic              rst,
  csr_el_req_if.sink        req,
  csr_el_rsp_if.source      rsp,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  localparam int RA_W = $clog2(MAX_ROWS + 1);
  localparam int EA_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;

  logic [CNT_W-1:0] row_count;
  logic             sel_row_count;

  logic              ptr_we;
  logic [RA_W-1:0]   ptr_waddr;
  logic [PTR_W-1:0]  ptr_wdata;
  logic [RA_W-1:0]   ptr_raddr;
  logic [PTR_W-1:0]  ptr_rdata;
  logic              ent_we;
  logic [EA_W-1:0]   ent_waddr;
  entry_word_t       ent_wdata;
  logic [EA_W-1:0]   ent_raddr;
  entry_word_t       ent_rdata;

  assign pready        = 1'b1;
  assign sel_row_count = (paddr[2:2] == REG_ROW_COUNT);

  always_ff @(posedge clk) begin
    if (rst) begin
      row_count <= '0;
    end else if (psel && penable && pwrite && pready && sel_row_count) begin
      row_count <= pwdata[CNT_W-1:0];
    end
  end

  assign prdata = sel_row_count ? 32'(row_count) : 32'd0;

  csr_el_ctrl #(
    .MAX_ROWS    (MAX_ROWS),
    .MAX_ENTRIES (MAX_ENTRIES),
    .RA_W        (RA_W),
    .EA_W        (EA_W)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .rsp       (rsp),
    .row_count (row_count),
    .ptr_we    (ptr_we),
    .ptr_waddr (ptr_waddr),
    .ptr_wdata (ptr_wdata),
    .ptr_raddr (ptr_raddr),
    .ptr_rdata (ptr_rdata),
    .ent_we    (ent_we),
    .ent_waddr (ent_waddr),
    .ent_wdata (ent_wdata),
    .ent_raddr (ent_raddr),
    .ent_rdata (ent_rdata)
  );

  csr_el_ram #(
    .DEPTH (MAX_ROWS + 1),
    .WIDTH (PTR_W),
    .AW    (RA_W)
  ) u_ptr_ram (
    .clk   (clk),
    .we    (ptr_we),
    .waddr (ptr_waddr),
    .wdata (ptr_wdata),
    .raddr (ptr_raddr),
    .rdata (ptr_rdata)
  );

  csr_el_ram #(
    .DEPTH (MAX_ENTRIES),
    .WIDTH (ENTRY_W),
    .AW    (EA_W)
  ) u_ent_ram (
    .clk   (clk),
    .we    (ent_we),
    .waddr (ent_waddr),
    .wdata (ent_wdata),
    .raddr (ent_raddr),
    .rdata (ent_rdata)
  );

endmodule
